FILE: hw/rtl/fractional_delay_hermite_defines.svh
// Assertion macros shared by the checker of the fractional delay line.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef FRACTIONAL_DELAY_HERMITE_DEFINES_SVH
`define FRACTIONAL_DELAY_HERMITE_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define FDH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define FDH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fdh_pkg.sv
// Package of the fractional delay line: field widths, defaults and the sequencer states.
// No dependencies; used by fractional_delay_hermite and its checker.
`default_nettype none

package fdh_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int DELAY_W       = 28;
   localparam int GUARD         = 8;
   localparam int DEPTH_DEF     = 4096;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_COEF = 6'b000100,
      ST_MLO  = 6'b001000,
      ST_MHI  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fractional_delay_hermite.sv
// Fractional delay line with 4-point Hermite interpolation, single module.
// Depends on fdh_pkg for widths, defaults and the sequencer state type.
// A result is offered after the read, coefficient and multiply states (later if the output
// is full). A new item is taken only after the last leaves DONE; the single read port (four
// reads) and the one shared multiplier, used twice for each of the three Horner steps, pace it.
// Reset (synchronous, active high) empties the store logically through a fill count and
// clears the write pointer; no clearing pass is needed, so the block is ready at once.
`default_nettype none

module fractional_delay_hermite #(
   parameter int DEPTH     = fdh_pkg::DEPTH_DEF,
   parameter int FRAC_BITS = fdh_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic signed [fdh_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic        [fdh_pkg::DELAY_W-1:0]   req_delay_fixed,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic signed [fdh_pkg::SAMPLE_W-1:0]  rsp_sample_out
);

   // Address width and the width of the tap position in Q(AW).FRAC_BITS.
   localparam int AW  = $clog2(DEPTH);
   localparam int PW  = AW + FRAC_BITS;
   localparam int EW  = (PW > fdh_pkg::DELAY_W) ? PW : fdh_pkg::DELAY_W;
   localparam int SW  = fdh_pkg::SAMPLE_W;
   // Raw doubled coefficients need four bits above a sample; then the guard bits.
   localparam int CW  = SW + 4;
   localparam int DW  = CW + fdh_pkg::GUARD;
   // The Horner accumulator stays below the sum of the coefficient magnitudes.
   localparam int RW  = DW + 2;
   // The accumulator is multiplied in two halves on a narrow shared multiplier.
   localparam int LO_W = RW / 2;
   localparam int HI_W = RW - LO_W;
   localparam int MA_W = HI_W + 1;
   localparam int MB_W = FRAC_BITS + 1;
   localparam int MP_W = MA_W + MB_W;
   localparam int PRW  = RW + FRAC_BITS + 1;
   localparam int YW   = RW + 1;
   localparam logic [2:0] READS      = 3'd4;
   localparam logic [1:0] LAST_STEP  = 2'd2;

   // Control state.
   fdh_pkg::state_type state_ff, state_in;
   logic [2:0]         rd_cnt_ff, rd_cnt_in;
   logic [1:0]         step_ff, step_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [AW:0]        fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rd_vld_ff;

   // Payload registers.
   logic signed [SW-1:0]   sample_ff;
   logic [AW-1:0]          base_ff;
   logic [FRAC_BITS-1:0]   frac_ff;
   logic signed [SW-1:0]   tap_ff [4];
   logic signed [SW-1:0]   mem_rd_ff;
   logic signed [DW-1:0]   d0_ff, d1_ff, d2_ff;
   logic signed [RW-1:0]   acc_ff, acc_in;
   logic signed [MP_W-1:0] lo_prod_ff;
   logic signed [SW-1:0]   rsp_sample_ff, rsp_sample_in;

   // The delay store itself: one write and one read port, read data registered.
   logic signed [SW-1:0]   store_ff [DEPTH];

   // Combinational helpers.
   logic [EW-1:0]          pos;
   logic [AW-1:0]          rd_addr;
   logic                   rd_addr_vld;
   logic                   out_free;
   logic                   wr_en;
   logic signed [CW-1:0]   e0, e1, e2, e3, e12;
   logic signed [CW-1:0]   c0, c1, c2, c3;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p;
   logic signed [PRW-1:0]  prod_full;
   logic signed [PRW-1:0]  prod_shift;
   logic signed [DW-1:0]   d_sel;
   logic signed [YW-1:0]   y_round;

   assign req_ready      = (state_ff == fdh_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // The output register may be reloaded when it is empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_en    = (state_ff == fdh_pkg::ST_DONE) && out_free;

   // Tap position: write pointer minus delay, wrapping modulo DEPTH in fixed point.
   assign pos = (EW'(wp_ff) << FRAC_BITS) - EW'(req_delay_fixed);

   // Neighbours n-1 .. n+2 are read in that order.
   assign rd_addr = base_ff + AW'(rd_cnt_ff[1:0]) - AW'(1);

   // Entries are written in address order from zero after reset, so an entry holds a real
   // sample only once the fill count has passed it; otherwise it reads as zero.
   assign rd_addr_vld = fill_ff[AW] || ({1'b0, rd_addr} < fill_ff);

   // Doubled Hermite coefficients, exact in CW bits.
   always_comb begin
      e0  = CW'(tap_ff[0]);
      e1  = CW'(tap_ff[1]);
      e2  = CW'(tap_ff[2]);
      e3  = CW'(tap_ff[3]);
      e12 = e1 - e2;
      c0  = e1 <<< 1;
      c1  = e2 - e0;
      c2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c3  = (e3 - e0) + (e12 <<< 1) + e12;
   end

   // Shared multiplier: the low half of the accumulator (unsigned) in state MLO of a
   // Horner step, the high half (signed) in state MHI.
   always_comb begin
      if (state_ff == fdh_pkg::ST_MLO) begin
         mul_a = MA_W'($signed({1'b0, acc_ff[LO_W-1:0]}));
      end else begin
         mul_a = MA_W'($signed(acc_ff[RW-1:LO_W]));
      end
      mul_b = $signed({1'b0, frac_ff});
      mul_p = mul_a * mul_b;
   end

   // Recombine both halves, floor-divide by 2^FRAC_BITS and add the next coefficient.
   always_comb begin
      prod_full  = (PRW'(mul_p) <<< LO_W) + PRW'(lo_prod_ff);
      prod_shift = prod_full >>> FRAC_BITS;
      case (step_ff)
         2'd0:    d_sel = d2_ff;
         2'd1:    d_sel = d1_ff;
         default: d_sel = d0_ff;
      endcase
      acc_in = RW'(prod_shift) + RW'(d_sel);
   end

   // Round to nearest with ties up, dropping the guard bits and the factor of two, then
   // saturate to the sample range.
   always_comb begin
      y_round = (YW'(acc_ff) + (YW'(1) <<< fdh_pkg::GUARD)) >>> (fdh_pkg::GUARD + 1);
      if (y_round > YW'(fdh_pkg::SAMPLE_MAX)) begin
         rsp_sample_in = fdh_pkg::SAMPLE_MAX;
      end else if (y_round < YW'(fdh_pkg::SAMPLE_MIN)) begin
         rsp_sample_in = fdh_pkg::SAMPLE_MIN;
      end else begin
         rsp_sample_in = SW'(y_round);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      step_in      = step_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         fdh_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in  = fdh_pkg::ST_READ;
               rd_cnt_in = '0;
            end
         end
         fdh_pkg::ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == READS) begin
               state_in = fdh_pkg::ST_COEF;
            end
         end
         fdh_pkg::ST_COEF: begin
            state_in = fdh_pkg::ST_MLO;
            step_in  = '0;
         end
         fdh_pkg::ST_MLO: begin
            state_in = fdh_pkg::ST_MHI;
         end
         fdh_pkg::ST_MHI: begin
            step_in = step_ff + 2'd1;
            if (step_ff == LAST_STEP) begin
               state_in = fdh_pkg::ST_DONE;
            end else begin
               state_in = fdh_pkg::ST_MLO;
            end
         end
         fdh_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               wp_in        = wp_ff + AW'(1);
               if (!fill_ff[AW]) begin
                  fill_in = fill_ff + (AW+1)'(1);
               end
               state_in = fdh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdh_pkg::ST_IDLE;
         rd_cnt_ff    <= '0;
         step_ff      <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         step_ff      <= step_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload path.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_sample_in;
         base_ff   <= pos[PW-1:FRAC_BITS];
         frac_ff   <= pos[FRAC_BITS-1:0];
      end
      if ((state_ff == fdh_pkg::ST_READ) && (rd_cnt_ff != 3'd0)) begin
         tap_ff[2'(rd_cnt_ff - 3'd1)] <= rd_vld_ff ? mem_rd_ff : '0;
      end
      if (state_ff == fdh_pkg::ST_COEF) begin
         d0_ff  <= DW'(c0) <<< fdh_pkg::GUARD;
         d1_ff  <= DW'(c1) <<< fdh_pkg::GUARD;
         d2_ff  <= DW'(c2) <<< fdh_pkg::GUARD;
         acc_ff <= RW'(c3) <<< fdh_pkg::GUARD;
      end
      if (state_ff == fdh_pkg::ST_MLO) begin
         lo_prod_ff <= mul_p;
      end
      if (state_ff == fdh_pkg::ST_MHI) begin
         acc_ff <= acc_in;
      end
      if (wr_en) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   // Store read port, with the fill check registered alongside the data.
   always_ff @(posedge clock) begin
      mem_rd_ff <= store_ff[rd_addr];
      rd_vld_ff <= rd_addr_vld;
   end

   // Store write port: the new sample goes in only after all four taps have been read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wp_ff] <= sample_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fdh_checker.sv
// Port-level checker for the fractional delay line, bound to its top level.
// Depends on fdh_pkg and the assertion macros in fractional_delay_hermite_defines.svh.
`default_nettype none
`include "fractional_delay_hermite_defines.svh"

module fdh_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [fdh_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   logic req_xfer;
   logic rsp_hold;

   assign req_xfer = req_valid && req_ready;
   assign rsp_hold = rsp_valid && !rsp_ready;

   // Reset leaves the output empty and the input open.
   `FDH_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "reset state wrong")

   // An accepted item keeps the block busy through its whole computation.
   `FDH_ASSERT(a_busy_span, clock, reset, req_xfer |-> ##12 !req_ready, "busy too short")

   // A new result only appears at the end of a computation, never while idle.
   `FDH_ASSERT(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "stray result")

   // A result that waits keeps its value.
   `FDH_ASSERT(a_rsp_hold, clock, reset, rsp_hold |=> rsp_valid && $stable(rsp_sample_out), "result dropped")

endmodule

bind fractional_delay_hermite fdh_checker u_fdh_checker (.*);

`default_nettype wire

FILE: tb/fdh_tap_checker.sv
// Checker for the fractional delay line: watches both channels, predicts each Hermite tap.
// Depends on fdh_pkg for widths and defaults; instantiated beside the block by tb_top.
module fdh_tap_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [fdh_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic        [fdh_pkg::DELAY_W-1:0]  req_delay_fixed,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [fdh_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output int                                  mismatches,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DEPTH = fdh_pkg::DEPTH_DEF;
   localparam int  FRAC  = fdh_pkg::FRAC_BITS_DEF;
   localparam int  AW    = $clog2(DEPTH);
   localparam int  SW    = fdh_pkg::SAMPLE_W;
   localparam int  GRD   = fdh_pkg::GUARD;

   logic signed [SW-1:0] line_store [DEPTH];
   logic        [AW-1:0] wr_ptr;
   logic signed [SW-1:0] expected_taps [$];
   int                   fault_count = 0;

   // Interpolated read for the given delay, taken before the new sample is stored.
   function automatic logic signed [SW-1:0] hermite_tap(input logic [fdh_pkg::DELAY_W-1:0] dly);
      longint pos, base, t, p0, p1, p2, p3, d0, d1, d2, d3, r, y;
      pos  = (longint'(wr_ptr) << FRAC) - longint'(dly);
      base = pos >>> FRAC;
      t    = pos & ((longint'(1) << FRAC) - 1);
      p0   = longint'(line_store[(base - 1) & (DEPTH - 1)]);
      p1   = longint'(line_store[base & (DEPTH - 1)]);
      p2   = longint'(line_store[(base + 1) & (DEPTH - 1)]);
      p3   = longint'(line_store[(base + 2) & (DEPTH - 1)]);
      d0   = (2 * p1) <<< GRD;
      d1   = (p2 - p0) <<< GRD;
      d2   = (2 * p0 - 5 * p1 + 4 * p2 - p3) <<< GRD;
      d3   = ((p3 - p0) + 3 * (p1 - p2)) <<< GRD;
      r    = d3;
      r    = ((r * t) >>> FRAC) + d2;
      r    = ((r * t) >>> FRAC) + d1;
      r    = ((r * t) >>> FRAC) + d0;
      y    = (r + (longint'(1) << GRD)) >>> (GRD + 1);
      if (y > longint'(fdh_pkg::SAMPLE_MAX)) y = longint'(fdh_pkg::SAMPLE_MAX);
      if (y < longint'(fdh_pkg::SAMPLE_MIN)) y = longint'(fdh_pkg::SAMPLE_MIN);
      return y[SW-1:0];
   endfunction

   task automatic flag_mismatch(input string what, input logic [SW-1:0] got,
                                input logic [SW-1:0] want);
      $display("%0t ns: sample_out %s: got %h, want %h", $realtime, what, got, want);
      fault_count++;
   endtask

   always @(posedge clock) begin
      logic signed [SW-1:0] want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) line_store[i] = '0;
         wr_ptr = '0;
         expected_taps.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_taps.push_back(hermite_tap(req_delay_fixed));
            line_store[wr_ptr] = req_sample_in;
            wr_ptr = wr_ptr + 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_taps.size() == 0) begin
               flag_mismatch("arrived with nothing expected", rsp_sample_out, 'x);
            end else begin
               want = expected_taps.pop_front();
               if (rsp_sample_out !== want) flag_mismatch("differs", rsp_sample_out, want);
            end
         end
      end
      mismatches  <= fault_count;
      outstanding <= expected_taps.size();
   end

endmodule

FILE: tb/tb_top.sv
// Top of the fractional delay line testbench: clock, reset, stimulus and verdict.
// Depends on fdh_pkg, the block fractional_delay_hermite and the checker fdh_tap_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC  = fdh_pkg::FRAC_BITS_DEF;
   localparam int INT_W = fdh_pkg::DELAY_W - FRAC;
   localparam int SW    = fdh_pkg::SAMPLE_W;
   localparam int DW    = fdh_pkg::DELAY_W;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [SW-1:0] req_sample_in;
   logic        [DW-1:0] req_delay_fixed;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [SW-1:0] rsp_sample_out;
   int                   mismatches;
   int                   outstanding;

   // Shared between the sender and the receiver: calm switches idling off on both
   // sides, and hold_out asks the receiver for one long hold-off.
   logic calm     = 1'b0;
   logic hold_out = 1'b0;

   fractional_delay_hermite dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_delay_fixed (req_delay_fixed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out)
   );

   fdh_tap_checker u_tap_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_delay_fixed (req_delay_fixed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one sample after a random gap and returns at the falling edge after its
   // transfer. The valid line is left high, so a caller that does not send again at
   // once must lower it itself.
   task automatic send_sample(input logic signed [SW-1:0] s, input logic [DW-1:0] d);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_in   <= s;
      req_delay_fixed <= d;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Receiver. After each transfer it holds ready low for a drawn number of cycles,
   // or for a long stretch when asked, so that the block's output and then its input
   // back up.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_out) begin
            hold_out = 1'b0;
            n = 300;
         end else begin
            n = calm ? 0 : $urandom_range(0, 4);
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      logic signed [SW-1:0] s;
      logic        [DW-1:0] d;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_in   = '0;
      req_delay_fixed = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The write pointer equals the number of transfers so far, so
      // the delays below aim the four taps at known entries. The first samples lay
      // down full-scale steps for the overshoot cases.
      send_sample(fdh_pkg::SAMPLE_MIN, '0);                       // zero delay, cleared store
      send_sample(fdh_pkg::SAMPLE_MAX, '1);                       // longest delay, wraps
      send_sample(fdh_pkg::SAMPLE_MAX, DW'(16'hFFFF));            // fraction only, largest
      send_sample(fdh_pkg::SAMPLE_MIN, DW'(1) << FRAC);           // whole-sample delay
      send_sample(fdh_pkg::SAMPLE_MIN, DW'(1));                   // smallest fraction
      // Taps on MIN, MAX, MAX, MIN halfway: overshoots past positive full scale.
      send_sample(fdh_pkg::SAMPLE_MAX, (DW'(4) << FRAC) - DW'(16'h8000));
      // Taps on MAX, MIN, MIN, MAX halfway: overshoots past negative full scale.
      send_sample(fdh_pkg::SAMPLE_MAX, (DW'(3) << FRAC) - DW'(16'h8000));
      send_sample(24'sh555555, DW'(2) << FRAC);
      send_sample(24'shAAAAAA, (DW'(7) << FRAC) - DW'(1));
      send_sample('0, (DW'(8) << FRAC) - DW'(16'hFFFF));
      send_sample(24'sd1, {{INT_W{1'b1}}, {FRAC{1'b0}}});         // one less than the store
      send_sample(-24'sd1, {1'b1, {(DW-1){1'b0}}});
      send_sample(fdh_pkg::SAMPLE_MAX, {1'b0, {(DW-1){1'b1}}});
      send_sample(fdh_pkg::SAMPLE_MIN, (DW'(9) << FRAC) + DW'(16'h4000));
      send_sample(SW'($urandom()), (DW'(3) << FRAC) + DW'(16'hC000));
      send_sample(SW'($urandom()), (DW'(1) << FRAC) + DW'(16'h0001));

      // Random part. Most delays stay short so that the taps land on samples that
      // were actually written; extremes of the samples are drawn often so that the
      // interpolation overshoots now and then.
      for (int i = 0; i < 500; i++) begin
         calm = ((i % 100) >= 60 && (i % 100) < 80) || (i >= 200 && i < 240);
         if (i == 200) hold_out = 1'b1;
         if (i == 350) begin
            // Let the block drain completely before carrying on.
            req_valid <= 1'b0;
            while (outstanding != 0) @(posedge clock);
            @(negedge clock);
         end
         case ($urandom_range(0, 7))
            0:       s = fdh_pkg::SAMPLE_MAX;
            1:       s = fdh_pkg::SAMPLE_MIN;
            2:       s = SW'($urandom_range(0, 511)) - 24'sd256;
            3:       s = {3'b011, 21'($urandom())};
            4:       s = {3'b100, 21'($urandom())};
            default: s = SW'($urandom());
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: d = {INT_W'($urandom_range(0, 24)), FRAC'($urandom())};
            4:          d = {INT_W'($urandom_range(0, 24)), {FRAC{1'b0}}};
            5, 6:       d = {INT_W'($urandom_range(0, 700)), FRAC'($urandom())};
            default:    d = DW'($urandom());
         endcase
         send_sample(s, d);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("timeout with %0d results still expected", outstanding);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/fdh_pkg.sv
hw/rtl/fractional_delay_hermite.sv
hw/rtl/fdh_checker.sv
tb/fdh_tap_checker.sv
tb/tb_top.sv
